// ----- sv/sps_pkg.sv -----
// Sleep package scanner: shared constants, register indexes and types.
// Used by sps_cell, sps_cand and aml_sleep_package_scanner.
`timescale 1ns / 1ps
`default_nettype none

package sps_pkg;

  localparam int unsigned WIN_DEPTH  = 12;
  localparam int unsigned BODY_START = 36;
  localparam int unsigned MIN_TABLE  = 48;
  localparam int unsigned LEN_POS0   = 4;

  localparam logic [7:0] NAME_MARK   = 8'h5F;
  localparam logic [7:0] PACKAGE_OP  = 8'h12;
  localparam logic [7:0] ZERO_OP     = 8'h00;
  localparam logic [7:0] ONE_OP      = 8'h01;
  localparam logic [7:0] BYTE_PREFIX = 8'h0A;

  localparam logic [7:0] NAME_A_RST = 8'd83;
  localparam logic [7:0] NAME_B_RST = 8'd53;

  localparam logic REG_NAME_A = 1'b0;
  localparam logic REG_NAME_B = 1'b1;

  typedef logic [WIN_DEPTH-1:0][7:0] win_t;

  typedef struct packed {
    logic [32:0] base;
    logic [31:0] lim;
    logic [7:0]  char_a;
    logic [7:0]  char_b;
  } cand_ctl_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] value;
  } cand_res_t;

endpackage

`default_nettype wire

// ----- sv/aml_sleep_package_scanner.sv -----
// Sleep package scanner top level: window cells, candidate checks, APB registers.
// Depends on sps_pkg, sps_cell and sps_cand.
//
// Usage:
//   in_*  : table bytes, one per beat, from offset zero; in_tlast on the final byte.
//   out_* : one result beat per table, out_tuser = found, out_tdata = sleep value.
//   cfg_* : APB registers, name_char_a at 0x0, name_char_b at 0x4; pready always high.
// Throughput: one byte per cycle while in_tready is high. A twelve-cell shift row
//   holds the latest bytes; the candidate check runs on it as each byte enters.
// Latency: the result beat is valid in the cycle after the last byte is accepted.
// Stall: the result waits in an output register; while it is held and out_tready
//   is low, in_tready is low, otherwise bytes flow on without a gap.
// Reset: rst_n clears the stream state and the output, and loads the name
//   characters with 'S' and '5'. After each table the stream state clears itself.
`timescale 1ns / 1ps
`default_nettype none

module aml_sleep_package_scanner
  import sps_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // in_tdata: [7:0] data_byte
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,
  input  wire logic        in_tlast,
  // out_tdata: [7:0] sleep_value
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [7:0]  out_tdata,
  // out_tuser: [0] found
  output logic             out_tuser,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready
);

  logic [7:0]  name_a_r;
  logic [7:0]  name_b_r;
  logic [31:0] pos_r, pos_nxt;
  logic [31:0] decl_r, decl_nxt, decl_upd;
  logic        match_r, match_nxt;
  logic [7:0]  val_r, val_nxt;
  logic        ovalid_r, ovalid_nxt;
  logic        ofound_r, ofound_nxt;
  logic [7:0]  oval_r, oval_nxt;

  logic        acc;
  logic        cfg_wr;
  logic [31:0] n;
  logic [31:0] lim;
  win_t        win_q;
  win_t        win_new;
  win_t        win_off;
  cand_ctl_t   ctl0, ctl1;
  cand_res_t   res0, res1;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      name_a_r <= NAME_A_RST;
      name_b_r <= NAME_B_RST;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_NAME_A: name_a_r <= cfg_pwdata[7:0];
        REG_NAME_B: name_b_r <= cfg_pwdata[7:0];
        default:    name_a_r <= name_a_r;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_NAME_A: cfg_prdata = {24'h0, name_a_r};
      REG_NAME_B: cfg_prdata = {24'h0, name_b_r};
      default:    cfg_prdata = 32'h0;
    endcase
  end

  assign in_tready = !ovalid_r || out_tready;
  assign acc       = in_tvalid && in_tready;

  for (genvar k = 0; k < WIN_DEPTH; k++) begin : g_cell
    if (k == WIN_DEPTH - 1) begin : g_tail
      assign win_new[k] = in_tdata;
      assign win_off[k] = 8'h00;
    end else begin : g_body
      assign win_new[k] = win_q[k+1];
      assign win_off[k] = win_new[k+1];
    end
    sps_cell u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .en   (acc),
      .clr  (in_tlast),
      .d_in (win_new[k]),
      .q    (win_q[k])
    );
  end

  assign n = (pos_r == 32'hFFFF_FFFF) ? pos_r : pos_r + 32'd1;

  always_comb begin
    decl_upd = decl_r;
    case (pos_r)
      32'(LEN_POS0):     decl_upd[7:0]   = in_tdata;
      32'(LEN_POS0 + 1): decl_upd[15:8]  = in_tdata;
      32'(LEN_POS0 + 2): decl_upd[23:16] = in_tdata;
      32'(LEN_POS0 + 3): decl_upd[31:24] = in_tdata;
      default:           decl_upd        = decl_r;
    endcase
  end

  assign lim = (decl_upd < n) ? decl_upd : n;

  always_comb begin
    ctl0.base   = {1'b0, n} - 33'(WIN_DEPTH);
    ctl0.lim    = lim;
    ctl0.char_a = name_a_r;
    ctl0.char_b = name_b_r;
    ctl1        = ctl0;
    ctl1.base   = ctl0.base + 33'd1;
  end

  sps_cand u_cand0 (
    .win(win_new),
    .ctl(ctl0),
    .res(res0)
  );

  sps_cand u_cand1 (
    .win(win_off),
    .ctl(ctl1),
    .res(res1)
  );

  always_comb begin
    pos_nxt    = pos_r;
    decl_nxt   = decl_r;
    match_nxt  = match_r;
    val_nxt    = val_r;
    ovalid_nxt = ovalid_r && !out_tready;
    ofound_nxt = ofound_r;
    oval_nxt   = oval_r;
    if (acc) begin
      if (in_tlast) begin
        pos_nxt    = 32'h0;
        decl_nxt   = 32'h0;
        match_nxt  = 1'b0;
        val_nxt    = 8'h00;
        ovalid_nxt = 1'b1;
        if (match_r) begin
          ofound_nxt = 1'b1;
          oval_nxt   = val_r;
        end else if (res0.hit) begin
          ofound_nxt = 1'b1;
          oval_nxt   = res0.value;
        end else if (res1.hit) begin
          ofound_nxt = 1'b1;
          oval_nxt   = res1.value;
        end else begin
          ofound_nxt = 1'b0;
          oval_nxt   = 8'h00;
        end
      end else begin
        pos_nxt  = n;
        decl_nxt = decl_upd;
        if (!match_r && res0.hit) begin
          match_nxt = 1'b1;
          val_nxt   = res0.value;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= 32'h0;
      decl_r   <= 32'h0;
      match_r  <= 1'b0;
      val_r    <= 8'h00;
      ovalid_r <= 1'b0;
      ofound_r <= 1'b0;
      oval_r   <= 8'h00;
    end else begin
      pos_r    <= pos_nxt;
      decl_r   <= decl_nxt;
      match_r  <= match_nxt;
      val_r    <= val_nxt;
      ovalid_r <= ovalid_nxt;
      ofound_r <= ofound_nxt;
      oval_r   <= oval_nxt;
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tuser  = ofound_r;
  assign out_tdata  = oval_r;

`ifndef SYNTHESIS
  a_last_gives_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_tlast) |=> ovalid_r)
    else $error("no result beat after last byte");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_tlast) |=> (pos_r == 32'h0 && !match_r && decl_r == 32'h0))
    else $error("stream state not cleared after last byte");

  a_match_needs_len: assert property (@(posedge clk) disable iff (!rst_n)
    match_r |-> (pos_r >= 32'(MIN_TABLE)))
    else $error("match latched in a short table");

  a_nofind_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && !ofound_r) |-> (oval_r == 8'h00))
    else $error("nonzero value without a find");
`endif

endmodule

`default_nettype wire

// ----- sv/sps_cell.sv -----
// One byte cell of the scan window: holds a byte and takes its neighbour's, or zero on clr.
// Depends on sps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sps_cell
  import sps_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       en,
  input  wire logic       clr,
  input  wire logic [7:0] d_in,
  output logic      [7:0] q
);

  logic [7:0] byte_r;
  logic [7:0] byte_nxt;

  always_comb begin
    byte_nxt = byte_r;
    if (en) begin
      byte_nxt = clr ? 8'h00 : d_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_r <= 8'h00;
    end else begin
      byte_r <= byte_nxt;
    end
  end

  assign q = byte_r;

endmodule

`default_nettype wire

// ----- sv/sps_cand.sv -----
// Candidate check at one window offset: name pattern, package header, integer.
// Depends on sps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sps_cand
  import sps_pkg::*;
(
  input  wire win_t      win,
  input  wire cand_ctl_t ctl,
  output cand_res_t      res
);

  logic [32:0] limx;
  logic [2:0]  skip;
  logic [3:0]  op_idx;
  logic [7:0]  op_byte;
  logic [7:0]  arg_byte;
  logic        ok_base;
  logic        ok_pat;
  logic        ok_len;
  logic        ok_op;
  logic        ok_arg;

  always_comb begin
    limx     = {1'b0, ctl.lim};
    skip     = {1'b0, win[5][7:6]} + 3'd1;
    op_idx   = 4'd6 + {1'b0, skip};
    op_byte  = win[op_idx];
    arg_byte = win[op_idx + 4'd1];

    ok_base = (ctl.lim >= 32'(MIN_TABLE)) && (ctl.base >= 33'(BODY_START)) &&
              ((ctl.base + 33'd10) < limx);
    ok_pat  = (win[0] == NAME_MARK) && (win[1] == ctl.char_a) &&
              (win[2] == ctl.char_b) && (win[3] == NAME_MARK) &&
              (win[4] == PACKAGE_OP);
    ok_len  = ((ctl.base + 33'd5 + 33'(skip)) < limx) &&
              ((ctl.base + 33'd6 + 33'(skip)) < limx);
    ok_arg  = (ctl.base + 33'd7 + 33'(skip)) < limx;

    ok_op     = 1'b0;
    res.value = 8'h00;
    if (op_byte == ZERO_OP) begin
      ok_op = 1'b1;
    end else if (op_byte == ONE_OP) begin
      ok_op     = 1'b1;
      res.value = 8'h01;
    end else if (op_byte == BYTE_PREFIX && ok_arg) begin
      ok_op     = 1'b1;
      res.value = arg_byte;
    end
    res.hit = ok_base && ok_pat && ok_len && ok_op;
  end

endmodule

`default_nettype wire
